@@ src/ctp_pkg.sv @@
// Shared widths, codes and word types for the closest-point-on-triangle pipeline.
// Used by every module in the block; depends on nothing.
package ctp_pkg;

  localparam int CW      = 32;
  localparam int DOTW    = 2 * (CW + 1) + 2;
  localparam int VW      = 2 * DOTW + 1;
  localparam int NUMW    = DOTW + 2;
  localparam int DENW    = VW + 3;
  localparam int MW      = DENW;
  localparam int DIG     = 7;
  localparam int NDIG    = (MW + DIG - 1) / DIG;
  localparam int PW      = 2 * MW;
  localparam int MUL_LAT = NDIG + 1;
  localparam int NW      = CW + 1 + VW + 2;
  localparam int QB      = CW + 8;
  localparam int QW      = QB + 1;
  localparam int DIV_LAT = QB + 1;
  localparam int LATENCY = 7 + 3 * MUL_LAT + DIV_LAT;

  typedef enum logic [2:0] {
    REG_A   = 3'd0,
    REG_B   = 3'd1,
    REG_AB  = 3'd2,
    REG_C   = 3'd3,
    REG_AC  = 3'd4,
    REG_BC  = 3'd5,
    REG_INT = 3'd6
  } region_t;

  typedef enum logic [1:0] {
    MODE_VTX,
    MODE_EDGE,
    MODE_INT
  } mode_t;

  typedef struct packed {
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;
    logic signed [CW-1:0] vertex_a_x;
    logic signed [CW-1:0] vertex_a_y;
    logic signed [CW-1:0] vertex_a_z;
    logic signed [CW-1:0] vertex_b_x;
    logic signed [CW-1:0] vertex_b_y;
    logic signed [CW-1:0] vertex_b_z;
    logic signed [CW-1:0] vertex_c_x;
    logic signed [CW-1:0] vertex_c_y;
    logic signed [CW-1:0] vertex_c_z;
  } in_t;

  typedef struct packed {
    logic signed [CW-1:0] closest_x;
    logic signed [CW-1:0] closest_y;
    logic signed [CW-1:0] closest_z;
    logic [2:0]           region;
    logic                 degenerate;
  } out_t;

  typedef struct {
    logic signed [CW-1:0]   p [3];
    logic signed [CW-1:0]   a [3];
    logic signed [CW-1:0]   b [3];
    logic signed [CW-1:0]   c [3];
    logic signed [CW:0]     ab [3];
    logic signed [CW:0]     ac [3];
    logic signed [CW:0]     bc [3];
    logic signed [CW:0]     ap [3];
    logic signed [CW:0]     bp [3];
    logic signed [CW:0]     cp [3];
    logic signed [CW:0]     dir [3];
    logic signed [DOTW-1:0] d [6];
    logic signed [VW-1:0]   va;
    logic signed [VW-1:0]   vb;
    logic signed [VW-1:0]   vc;
    region_t                region;
    mode_t                  mode;
    logic signed [NUMW-1:0] num;
    logic signed [DENW-1:0] den;
    logic signed [NW-1:0]   nsum [3];
    logic                   degen;
  } ctx_t;

endpackage

@@ src/closest_point_on_triangle_top.sv @@
// Top level of the closest-point-on-triangle pipeline.
// Depends on ctp_pkg, ctp_mul and ctp_div.
//
// One query word (point and three vertices) is taken on every clock in which start is high;
// busy never rises. Each result word appears on out_data with out_valid for one cycle,
// after passing through three banks of digit-serial multipliers of 21 stages each, a 41-stage
// divider and seven registered stages of sums and region tests. Results leave in query order
// and cannot be held off.
module closest_point_on_triangle_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  ctp_pkg::in_t  in_data,
  output logic          out_valid,
  output ctp_pkg::out_t out_data
);

  localparam int IA [6] = '{0, 2, 4, 0, 2, 4};
  localparam int IB [6] = '{3, 1, 1, 5, 5, 3};

  ctp_pkg::ctx_t c0_r, c1_nxt, c1_r, c2_nxt, c2_r, c3_nxt, c3_r, c4_nxt, c4_r, c5_nxt, c5_r;
  ctp_pkg::ctx_t c1d_r [ctp_pkg::MUL_LAT];
  ctp_pkg::ctx_t c2d_r [ctp_pkg::MUL_LAT];
  ctp_pkg::ctx_t c4d_r [ctp_pkg::MUL_LAT];
  ctp_pkg::ctx_t c5d_r [ctp_pkg::DIV_LAT];
  logic v0_r, v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [ctp_pkg::MUL_LAT-1:0] v1d_r, v2d_r, v4d_r;
  logic [ctp_pkg::DIV_LAT-1:0] v5d_r;
  ctp_pkg::out_t out_nxt, out_r;
  logic out_valid_r;

  logic signed [ctp_pkg::PW-1:0] p1 [6][3];
  logic signed [ctp_pkg::PW-1:0] p2 [6];
  logic signed [ctp_pkg::PW-1:0] p3 [6];
  logic signed [ctp_pkg::QW-1:0] q [3];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    c0_r.p <= '{in_data.point_x, in_data.point_y, in_data.point_z};
    c0_r.a <= '{in_data.vertex_a_x, in_data.vertex_a_y, in_data.vertex_a_z};
    c0_r.b <= '{in_data.vertex_b_x, in_data.vertex_b_y, in_data.vertex_b_z};
    c0_r.c <= '{in_data.vertex_c_x, in_data.vertex_c_y, in_data.vertex_c_z};
    c1_r <= c1_nxt;
    c2_r <= c2_nxt;
    c3_r <= c3_nxt;
    c4_r <= c4_nxt;
    c5_r <= c5_nxt;
    out_r <= out_nxt;
    c1d_r[0] <= c1_r;
    c2d_r[0] <= c2_r;
    c4d_r[0] <= c4_r;
    c5d_r[0] <= c5_r;
    for (int i = 1; i < ctp_pkg::MUL_LAT; i++) begin
      c1d_r[i] <= c1d_r[i-1];
      c2d_r[i] <= c2d_r[i-1];
      c4d_r[i] <= c4d_r[i-1];
    end
    for (int i = 1; i < ctp_pkg::DIV_LAT; i++) begin
      c5d_r[i] <= c5d_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v1d_r <= '0;
      v2d_r <= '0;
      v4d_r <= '0;
      v5d_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      v0_r <= start && !busy;
      v1_r <= v0_r;
      v1d_r <= {v1d_r[ctp_pkg::MUL_LAT-2:0], v1_r};
      v2_r <= v1d_r[ctp_pkg::MUL_LAT-1];
      v2d_r <= {v2d_r[ctp_pkg::MUL_LAT-2:0], v2_r};
      v3_r <= v2d_r[ctp_pkg::MUL_LAT-1];
      v4_r <= v3_r;
      v4d_r <= {v4d_r[ctp_pkg::MUL_LAT-2:0], v4_r};
      v5_r <= v4d_r[ctp_pkg::MUL_LAT-1];
      v5d_r <= {v5d_r[ctp_pkg::DIV_LAT-2:0], v5_r};
      out_valid_r <= v5d_r[ctp_pkg::DIV_LAT-1];
    end
  end

  // Edge vectors and offsets of the query point from each vertex.
  always_comb begin
    c1_nxt = c0_r;
    for (int k = 0; k < 3; k++) begin
      c1_nxt.ab[k] = (ctp_pkg::CW+1)'(c0_r.b[k]) - (ctp_pkg::CW+1)'(c0_r.a[k]);
      c1_nxt.ac[k] = (ctp_pkg::CW+1)'(c0_r.c[k]) - (ctp_pkg::CW+1)'(c0_r.a[k]);
      c1_nxt.bc[k] = (ctp_pkg::CW+1)'(c0_r.c[k]) - (ctp_pkg::CW+1)'(c0_r.b[k]);
      c1_nxt.ap[k] = (ctp_pkg::CW+1)'(c0_r.p[k]) - (ctp_pkg::CW+1)'(c0_r.a[k]);
      c1_nxt.bp[k] = (ctp_pkg::CW+1)'(c0_r.p[k]) - (ctp_pkg::CW+1)'(c0_r.b[k]);
      c1_nxt.cp[k] = (ctp_pkg::CW+1)'(c0_r.p[k]) - (ctp_pkg::CW+1)'(c0_r.c[k]);
    end
  end

  for (genvar g = 0; g < 6; g++) begin : g_dot
    for (genvar k = 0; k < 3; k++) begin : g_axis
      logic signed [ctp_pkg::MW-1:0] ua, ub;
      assign ua = (g % 2 == 0) ? ctp_pkg::MW'(c1_r.ab[k]) : ctp_pkg::MW'(c1_r.ac[k]);
      assign ub = (g / 2 == 0) ? ctp_pkg::MW'(c1_r.ap[k]) :
                  (g / 2 == 1) ? ctp_pkg::MW'(c1_r.bp[k]) : ctp_pkg::MW'(c1_r.cp[k]);
      ctp_mul u_mul (.clk(clk), .a_i(ua), .b_i(ub), .p_o(p1[g][k]));
    end
  end

  always_comb begin
    c2_nxt = c1d_r[ctp_pkg::MUL_LAT-1];
    for (int g = 0; g < 6; g++) begin
      c2_nxt.d[g] = ctp_pkg::DOTW'(p1[g][0] + p1[g][1] + p1[g][2]);
    end
  end

  for (genvar g = 0; g < 6; g++) begin : g_bary
    ctp_mul u_mul (
      .clk(clk),
      .a_i(ctp_pkg::MW'(c2_r.d[IA[g]])),
      .b_i(ctp_pkg::MW'(c2_r.d[IB[g]])),
      .p_o(p2[g])
    );
  end

  always_comb begin
    c3_nxt = c2d_r[ctp_pkg::MUL_LAT-1];
    c3_nxt.vc = ctp_pkg::VW'(p2[0] - p2[1]);
    c3_nxt.vb = ctp_pkg::VW'(p2[2] - p2[3]);
    c3_nxt.va = ctp_pkg::VW'(p2[4] - p2[5]);
  end

  // Region tests in the standard order: A, B, AB, C, AC, BC, interior.
  always_comb begin
    logic signed [ctp_pkg::NUMW-1:0] d1, d2, d3, d4, d5, d6, e1, e2;
    d1 = ctp_pkg::NUMW'(c3_r.d[0]);
    d2 = ctp_pkg::NUMW'(c3_r.d[1]);
    d3 = ctp_pkg::NUMW'(c3_r.d[2]);
    d4 = ctp_pkg::NUMW'(c3_r.d[3]);
    d5 = ctp_pkg::NUMW'(c3_r.d[4]);
    d6 = ctp_pkg::NUMW'(c3_r.d[5]);
    e1 = d4 - d3;
    e2 = d5 - d6;
    c4_nxt = c3_r;
    c4_nxt.num = d1;
    c4_nxt.den = ctp_pkg::DENW'(1);
    c4_nxt.dir = c3_r.ab;
    c4_nxt.mode = ctp_pkg::MODE_VTX;
    c4_nxt.degen = 1'b0;
    if (d1 <= 0 && d2 <= 0) begin
      c4_nxt.region = ctp_pkg::REG_A;
    end else if (d3 >= 0 && d4 <= d3) begin
      c4_nxt.region = ctp_pkg::REG_B;
    end else if (c3_r.vc <= 0 && d1 >= 0 && d3 <= 0) begin
      c4_nxt.region = ctp_pkg::REG_AB;
      c4_nxt.mode = ctp_pkg::MODE_EDGE;
      c4_nxt.num = d1;
      c4_nxt.den = ctp_pkg::DENW'(d1) - ctp_pkg::DENW'(d3);
      c4_nxt.dir = c3_r.ab;
    end else if (d6 >= 0 && d5 <= d6) begin
      c4_nxt.region = ctp_pkg::REG_C;
    end else if (c3_r.vb <= 0 && d2 >= 0 && d6 <= 0) begin
      c4_nxt.region = ctp_pkg::REG_AC;
      c4_nxt.mode = ctp_pkg::MODE_EDGE;
      c4_nxt.num = d2;
      c4_nxt.den = ctp_pkg::DENW'(d2) - ctp_pkg::DENW'(d6);
      c4_nxt.dir = c3_r.ac;
    end else if (c3_r.va <= 0 && e1 >= 0 && e2 >= 0) begin
      c4_nxt.region = ctp_pkg::REG_BC;
      c4_nxt.mode = ctp_pkg::MODE_EDGE;
      c4_nxt.num = e1;
      c4_nxt.den = ctp_pkg::DENW'(e1) + ctp_pkg::DENW'(e2);
      c4_nxt.dir = c3_r.bc;
    end else begin
      c4_nxt.region = ctp_pkg::REG_INT;
      c4_nxt.mode = ctp_pkg::MODE_INT;
      c4_nxt.den = ctp_pkg::DENW'(c3_r.va) + ctp_pkg::DENW'(c3_r.vb) +
                   ctp_pkg::DENW'(c3_r.vc);
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_num
    logic intr;
    assign intr = (c4_r.mode == ctp_pkg::MODE_INT);
    ctp_mul u_mul_a (
      .clk(clk),
      .a_i(intr ? ctp_pkg::MW'(c4_r.ab[k]) : ctp_pkg::MW'(c4_r.dir[k])),
      .b_i(intr ? ctp_pkg::MW'(c4_r.vb) : ctp_pkg::MW'(c4_r.num)),
      .p_o(p3[k])
    );
    ctp_mul u_mul_b (
      .clk(clk),
      .a_i(ctp_pkg::MW'(c4_r.ac[k])),
      .b_i(intr ? ctp_pkg::MW'(c4_r.vc) : '0),
      .p_o(p3[3+k])
    );
  end

  always_comb begin
    c5_nxt = c4d_r[ctp_pkg::MUL_LAT-1];
    for (int k = 0; k < 3; k++) begin
      c5_nxt.nsum[k] = ctp_pkg::NW'(p3[k] + p3[3+k]);
    end
    if (c5_nxt.mode != ctp_pkg::MODE_VTX && c5_nxt.den == 0) begin
      c5_nxt.mode = ctp_pkg::MODE_VTX;
      c5_nxt.region = ctp_pkg::REG_A;
      c5_nxt.degen = 1'b1;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_div
    ctp_div u_div (.clk(clk), .n_i(c5_r.nsum[k]), .d_i(c5_r.den), .q_o(q[k]));
  end

  always_comb begin
    ctp_pkg::ctx_t cx;
    logic signed [ctp_pkg::CW-1:0] base [3];
    logic signed [ctp_pkg::QW:0] sum;
    logic signed [ctp_pkg::CW-1:0] res [3];
    cx = c5d_r[ctp_pkg::DIV_LAT-1];
    sum = '0;
    for (int k = 0; k < 3; k++) begin
      base[k] = (cx.region == ctp_pkg::REG_B || cx.region == ctp_pkg::REG_BC) ? cx.b[k] :
                (cx.region == ctp_pkg::REG_C) ? cx.c[k] : cx.a[k];
      if (cx.mode == ctp_pkg::MODE_VTX) begin
        res[k] = base[k];
      end else begin
        sum = (ctp_pkg::QW+1)'(base[k]) + (ctp_pkg::QW+1)'(q[k]);
        if (sum[ctp_pkg::QW:ctp_pkg::CW-1] != '0 && sum[ctp_pkg::QW:ctp_pkg::CW-1] != '1) begin
          res[k] = sum[ctp_pkg::QW] ? {1'b1, {(ctp_pkg::CW-1){1'b0}}}
                                    : {1'b0, {(ctp_pkg::CW-1){1'b1}}};
        end else begin
          res[k] = sum[ctp_pkg::CW-1:0];
        end
      end
    end
    out_nxt.closest_x = res[0];
    out_nxt.closest_y = res[1];
    out_nxt.closest_z = res[2];
    out_nxt.region = cx.region;
    out_nxt.degenerate = cx.degen;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##(ctp_pkg::LATENCY) out_valid)
    else $error("query word did not produce a result word on time");
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, ctp_pkg::LATENCY))
    else $error("result word without a matching query word");
  a_degen_a: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |-> out_data.region == ctp_pkg::REG_A)
    else $error("degenerate result not reported in vertex A region");
  a_region_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.region <= ctp_pkg::REG_INT)
    else $error("result word carries an unused region code");

endmodule

@@ src/ctp_mul.sv @@
// Pipelined signed multiplier: one digit of the second operand per stage.
// Depends on ctp_pkg for operand width, digit size and stage count.
module ctp_mul (
  input  logic                            clk,
  input  logic signed [ctp_pkg::MW-1:0]   a_i,
  input  logic signed [ctp_pkg::MW-1:0]   b_i,
  output logic signed [ctp_pkg::PW-1:0]   p_o
);

  logic                     neg_r  [ctp_pkg::NDIG+1];
  logic [ctp_pkg::MW-1:0]   amag_r [ctp_pkg::NDIG+1];
  logic [ctp_pkg::MW-1:0]   bmag_r [ctp_pkg::NDIG+1];
  logic [ctp_pkg::PW-1:0]   acc_r  [ctp_pkg::NDIG+1];

  always_ff @(posedge clk) begin
    neg_r[0]  <= a_i[ctp_pkg::MW-1] ^ b_i[ctp_pkg::MW-1];
    amag_r[0] <= a_i[ctp_pkg::MW-1] ? -a_i : a_i;
    bmag_r[0] <= b_i[ctp_pkg::MW-1] ? -b_i : b_i;
    acc_r[0]  <= '0;
    for (int i = 1; i <= ctp_pkg::NDIG; i++) begin
      neg_r[i]  <= neg_r[i-1];
      amag_r[i] <= amag_r[i-1];
      bmag_r[i] <= bmag_r[i-1];
      acc_r[i]  <= acc_r[i-1] +
                   ((ctp_pkg::PW'(amag_r[i-1]) *
                     ctp_pkg::PW'(bmag_r[i-1][ctp_pkg::DIG*(i-1) +: ctp_pkg::DIG]))
                    << (ctp_pkg::DIG * (i-1)));
    end
  end

  assign p_o = neg_r[ctp_pkg::NDIG] ? -$signed(acc_r[ctp_pkg::NDIG])
                                    : $signed(acc_r[ctp_pkg::NDIG]);

endmodule

@@ src/ctp_div.sv @@
// Pipelined restoring divider, signed and truncating toward zero, one quotient bit a stage.
// Depends on ctp_pkg for numerator, divisor and quotient widths.
module ctp_div (
  input  logic                            clk,
  input  logic signed [ctp_pkg::NW-1:0]   n_i,
  input  logic signed [ctp_pkg::DENW-1:0] d_i,
  output logic signed [ctp_pkg::QW-1:0]   q_o
);

  logic                      neg_r [ctp_pkg::QB+1];
  logic [ctp_pkg::NW-1:0]    r_r   [ctp_pkg::QB+1];
  logic [ctp_pkg::DENW-1:0]  dm_r  [ctp_pkg::QB+1];
  logic [ctp_pkg::QB-1:0]    q_r   [ctp_pkg::QB+1];

  always_ff @(posedge clk) begin
    logic [ctp_pkg::NW+ctp_pkg::QB-1:0] sh;
    logic [ctp_pkg::NW+ctp_pkg::QB-1:0] rx;
    neg_r[0] <= n_i[ctp_pkg::NW-1] ^ d_i[ctp_pkg::DENW-1];
    r_r[0]   <= n_i[ctp_pkg::NW-1] ? -n_i : n_i;
    dm_r[0]  <= d_i[ctp_pkg::DENW-1] ? -d_i : d_i;
    q_r[0]   <= '0;
    for (int j = 1; j <= ctp_pkg::QB; j++) begin
      sh = (ctp_pkg::NW+ctp_pkg::QB)'(dm_r[j-1]) << (ctp_pkg::QB - j);
      rx = (ctp_pkg::NW+ctp_pkg::QB)'(r_r[j-1]);
      neg_r[j] <= neg_r[j-1];
      dm_r[j]  <= dm_r[j-1];
      if (rx >= sh) begin
        r_r[j] <= ctp_pkg::NW'(rx - sh);
        q_r[j] <= q_r[j-1] | (ctp_pkg::QB'(1) << (ctp_pkg::QB - j));
      end else begin
        r_r[j] <= r_r[j-1];
        q_r[j] <= q_r[j-1];
      end
    end
  end

  assign q_o = neg_r[ctp_pkg::QB] ? -$signed({1'b0, q_r[ctp_pkg::QB]})
                                  : $signed({1'b0, q_r[ctp_pkg::QB]});

endmodule
